// ----- hdl/plc_pkg.sv -----
// plc_pkg: shared types and constants for the LED chain loader
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package plc_pkg;

  // fixed field widths
  localparam int ACTION_W   = 3;
  localparam int CHANNEL_W  = 7;
  localparam int LEVEL_BITS = 12;
  localparam int STATUS_W   = 2;
  localparam int DEVCNT_W   = 3;

  // chained driver geometry
  localparam int CHANNELS_PER_DEVICE = 24;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};

  // configuration port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DEVICE_COUNT = 1'b0
  } reg_idx_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SET    = 3'd0,
    ACT_READ   = 3'd1,
    ACT_COMMIT = 3'd2,
    ACT_ON     = 3'd3,
    ACT_BLANK  = 3'd4,
    ACT_TICK   = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAN  = 2'd1,
    ST_BAD_LEVEL = 2'd2,
    ST_BUSY      = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/plc_if.sv -----
// plc_req_if / plc_res_if: valid-ready channels for requests and results
// depends on plc_pkg for field widths
`default_nettype none

interface plc_req_if;
  import plc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [CHANNEL_W-1:0]  channel;
  logic [LEVEL_BITS-1:0] level;

  modport source (output valid, action, channel, level, input ready);
  modport sink   (input valid, action, channel, level, output ready);
endinterface

interface plc_res_if;
  import plc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] read_level;
  logic [STATUS_W-1:0]   status;
  logic                  serial_bit;
  logic                  shift_pulse;
  logic                  latch_pulse;
  logic                  blank_level;
  logic                  busy_res;

  modport source (output valid, read_level, status, serial_bit, shift_pulse, latch_pulse,
                  blank_level, busy_res, input ready);
  modport sink   (input valid, read_level, status, serial_bit, shift_pulse, latch_pulse,
                  blank_level, busy_res, output ready);
endinterface

`default_nettype wire

// ----- hdl/plc_store.sv -----
// plc_store: channel level memory, one write and one registered read port
// clears every entry to full scale after reset; depends on plc_pkg
`default_nettype none

module plc_store #(
  parameter int DEPTH = 96,
  parameter int AW    = 7
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [AW-1:0]                  wr_addr,
  input  wire logic [plc_pkg::LEVEL_BITS-1:0] wr_data,
  input  wire logic                           rd_en,
  input  wire logic [AW-1:0]                  rd_addr,
  output logic      [plc_pkg::LEVEL_BITS-1:0] rd_data,
  output logic                                ready
);
  import plc_pkg::*;

  logic [LEVEL_BITS-1:0] mem [DEPTH];
  logic [AW-1:0]         clr_addr;
  logic                  clearing;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // write port shared by the sweep and the sequencer
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= LEVEL_MAX;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign ready = !clearing;

endmodule

`default_nettype wire

// ----- hdl/plc_cfg.sv -----
// plc_cfg: APB-style register file holding the device count
// writes are dropped while a commit runs; depends on plc_pkg
`default_nettype none

module plc_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [plc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [plc_pkg::PDATA_W-1:0]  pwdata,
  output logic      [plc_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  input  wire logic                         busy,
  output logic      [plc_pkg::DEVCNT_W-1:0] device_count
);
  import plc_pkg::*;

  reg_idx_t reg_idx;
  logic     wr_req;

  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_req  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // device count register
  always_ff @(posedge clk) begin
    if (rst) begin
      device_count <= DEVCNT_W'(1);
    end else if (wr_req && !busy && reg_idx == REG_DEVICE_COUNT) begin
      device_count <= pwdata[DEVCNT_W-1:0];
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_DEVICE_COUNT: prdata = PDATA_W'(device_count);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/pwm_led_chain_loader.sv -----
// pwm_led_chain_loader: top level, request sequencer and result register
// depends on plc_pkg, plc_if, plc_store and plc_cfg
// Sequence: a request is taken only in S_IDLE and its memory read is
// registered; S_EXEC then executes it, writes back and registers the result,
// stalling while the previous result still waits. The result register lets a
// request be taken while the previous result still waits. After reset the
// store is swept to full scale, one entry a cycle, with no request accepted.
`default_nettype none

module pwm_led_chain_loader #(
  parameter int MAX_DEVICES = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [plc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [plc_pkg::PDATA_W-1:0] pwdata,
  output logic      [plc_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  plc_req_if.sink                          req,
  plc_res_if.source                        res
);
  import plc_pkg::*;

  localparam int STORE_DEPTH = MAX_DEVICES * CHANNELS_PER_DEVICE;
  localparam int AW   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int NW   = $clog2(STORE_DEPTH + 1);
  localparam int CMPW = (NW > CHANNEL_W) ? NW : CHANNEL_W;
  localparam int DCW  = ($clog2(MAX_DEVICES + 1) > DEVCNT_W) ?
                        $clog2(MAX_DEVICES + 1) : DEVCNT_W;
  localparam int SBW  = 4;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                state;
  action_t               act;
  logic [CHANNEL_W-1:0]  chan;
  logic [LEVEL_BITS-1:0] lvl;
  logic [CHANNEL_W-1:0]  shift_channel, shift_channel_next;
  logic [SBW-1:0]        shift_bit, shift_bit_next;
  logic                  shifting, shifting_next;
  logic                  latch_due, latch_due_next;
  logic                  blanked, blanked_next;

  logic [LEVEL_BITS-1:0] rd_level_next;
  status_t               status_next;
  logic                  sbit_next, spulse_next, lpulse_next;

  logic [DEVCNT_W-1:0]   device_count;
  logic [DCW-1:0]        dc_ext, dc_eff;
  logic [CMPW-1:0]       n_use;
  logic                  chan_ok;
  logic                  busy;
  logic                  accept, finish;
  logic                  store_ready;
  logic [CHANNEL_W-1:0]  in_chan_sel;
  logic [CHANNEL_W-1:0]  sc_inc;
  logic                  wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [LEVEL_BITS-1:0] rd_data;

  // configuration registers
  plc_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .busy         (busy),
    .device_count (device_count)
  );

  // channel store
  plc_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (lvl),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .ready   (store_ready)
  );

  // channels in use from the clamped device count
  always_comb begin
    dc_ext = DCW'(device_count);
    if (dc_ext == '0) begin
      dc_eff = DCW'(1);
    end else if (dc_ext > DCW'(MAX_DEVICES)) begin
      dc_eff = DCW'(MAX_DEVICES);
    end else begin
      dc_eff = dc_ext;
    end
  end

  assign n_use   = CMPW'(dc_eff) * CMPW'(CHANNELS_PER_DEVICE);
  assign chan_ok = CMPW'(chan) < n_use;
  assign busy    = shifting || latch_due;

  // handshake
  assign req.ready = (state == S_IDLE) && store_ready;
  assign accept    = req.valid && req.ready;
  assign finish    = (state == S_EXEC) && (!res.valid || res.ready);

  // memory addresses: a tick reads the channel being shifted
  assign in_chan_sel = (action_t'(req.action) == ACT_TICK) ? shift_channel : req.channel;
  assign rd_addr     = AW'(in_chan_sel);
  assign wr_addr     = AW'(chan);

  // execute the held request against the read data
  always_comb begin
    shift_channel_next = shift_channel;
    shift_bit_next     = shift_bit;
    shifting_next      = shifting;
    latch_due_next     = latch_due;
    blanked_next       = blanked;
    rd_level_next      = '0;
    status_next        = ST_OK;
    sbit_next          = 1'b0;
    spulse_next        = 1'b0;
    lpulse_next        = 1'b0;
    wr_en              = 1'b0;
    sc_inc             = shift_channel + 1'b1;
    case (act)
      ACT_SET: begin
        if (busy) begin
          status_next = ST_BUSY;
        end else if (!chan_ok) begin
          status_next = ST_BAD_CHAN;
        end else begin
          wr_en = finish;
        end
      end
      ACT_READ: begin
        if (!chan_ok) begin
          status_next = ST_BAD_CHAN;
        end else begin
          rd_level_next = rd_data;
        end
      end
      ACT_COMMIT: begin
        if (busy) begin
          status_next = ST_BUSY;
        end else begin
          shifting_next      = 1'b1;
          shift_channel_next = '0;
          shift_bit_next     = '0;
        end
      end
      ACT_ON:    blanked_next = 1'b0;
      ACT_BLANK: blanked_next = 1'b1;
      ACT_TICK: begin
        if (latch_due) begin
          lpulse_next    = 1'b1;
          latch_due_next = 1'b0;
        end else if (shifting) begin
          // msb first
          sbit_next   = rd_data[SBW'(LEVEL_BITS - 1) - shift_bit];
          spulse_next = 1'b1;
          if (shift_bit >= SBW'(LEVEL_BITS - 1)) begin
            shift_bit_next = '0;
            if (CMPW'(sc_inc) >= n_use) begin
              shifting_next      = 1'b0;
              latch_due_next     = 1'b1;
              shift_channel_next = '0;
            end else begin
              shift_channel_next = sc_inc;
            end
          end else begin
            shift_bit_next = shift_bit + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // sequencer state, commit state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      shift_channel <= '0;
      shift_bit     <= '0;
      shifting      <= 1'b0;
      latch_due     <= 1'b0;
      blanked       <= 1'b0;
      res.valid     <= 1'b0;
    end else begin
      // result valid: set when a request finishes, cleared once taken
      if (finish) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (finish) begin
            state         <= S_IDLE;
            shift_channel <= shift_channel_next;
            shift_bit     <= shift_bit_next;
            shifting      <= shifting_next;
            latch_due     <= latch_due_next;
            blanked       <= blanked_next;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      act  <= action_t'(req.action);
      chan <= req.channel;
      lvl  <= req.level;
    end
    if (finish) begin
      res.read_level  <= rd_level_next;
      res.status      <= status_next;
      res.serial_bit  <= sbit_next;
      res.shift_pulse <= spulse_next;
      res.latch_pulse <= lpulse_next;
      res.blank_level <= blanked_next;
      res.busy_res    <= shifting_next || latch_due_next;
    end
  end

endmodule

`default_nettype wire

// ----- test/pwm_led_chain_loader_test.sv -----
// pwm_led_chain_loader_test: self-checking bench for the led chain loader
// depends on plc_pkg, plc_if and pwm_led_chain_loader; requests come from a queue,
// results are checked against an in-bench model of the channel store and shifter
`timescale 1ns / 1ps

module pwm_led_chain_loader_test;
  import plc_pkg::*;

  localparam int DEVICES     = 4;
  localparam int STORE_DEPTH = DEVICES * CHANNELS_PER_DEVICE;
  localparam int CYCLE_LIMIT = 200000;

  // action codes with no meaning, ignored by the block
  localparam logic [ACTION_W-1:0] ACT_UNDEF_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic [ACTION_W-1:0]   action;
    logic [CHANNEL_W-1:0]  channel;
    logic [LEVEL_BITS-1:0] level;
  } led_cmd_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] read_level;
    status_t               status;
    logic                  serial_bit;
    logic                  shift_pulse;
    logic                  latch_pulse;
    logic                  blank_level;
    logic                  busy_res;
  } led_out_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  plc_req_if req_ch ();
  plc_res_if res_ch ();

  pwm_led_chain_loader #(
    .MAX_DEVICES(DEVICES)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .req    (req_ch),
    .res    (res_ch)
  );

  // queues: requests waiting to be sent, results still owed by the block
  led_cmd_t pending_cmds[$];
  led_out_t expected_out[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int cycles;
  int gen_ticks_left;

  // shadow of the block state
  logic [LEVEL_BITS-1:0] level_mem [STORE_DEPTH];
  logic [CHANNEL_W-1:0]  out_chan;
  logic [3:0]            out_bit;
  logic                  commit_active;
  logic                  latch_pending;
  logic                  blank_on;
  logic [DEVCNT_W-1:0]   dev_count;

  // clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // channels covered by the current device count, out-of-range counts clamped
  function automatic int chans_in_use(logic [DEVCNT_W-1:0] d);
    int k;
    k = (d == 0) ? 1 : ((d > DEVICES) ? DEVICES : int'(d));
    return k * CHANNELS_PER_DEVICE;
  endfunction

  // apply one request to the shadow state and return the result it causes
  function automatic led_out_t apply_request(led_cmd_t c);
    led_out_t o;
    int       n;
    logic     busy;
    n    = chans_in_use(dev_count);
    busy = commit_active || latch_pending;
    o    = '0;
    o.status = ST_OK;
    case (c.action)
      ACT_SET: begin
        if (busy) o.status = ST_BUSY;
        else if (int'(c.channel) >= n) o.status = ST_BAD_CHAN;
        else level_mem[c.channel] = c.level;
      end
      ACT_READ: begin
        if (int'(c.channel) >= n) o.status = ST_BAD_CHAN;
        else o.read_level = level_mem[c.channel];
      end
      ACT_COMMIT: begin
        if (busy) begin
          o.status = ST_BUSY;
        end else begin
          commit_active = 1'b1;
          out_chan      = '0;
          out_bit       = '0;
        end
      end
      ACT_ON: blank_on = 1'b0;
      ACT_BLANK: blank_on = 1'b1;
      ACT_TICK: begin
        if (latch_pending) begin
          o.latch_pulse = 1'b1;
          latch_pending = 1'b0;
        end else if (commit_active) begin
          o.serial_bit  = level_mem[out_chan][LEVEL_BITS-1-out_bit];
          o.shift_pulse = 1'b1;
          if (out_bit == LEVEL_BITS - 1) begin
            out_bit  = '0;
            out_chan = out_chan + 1'b1;
            if (int'(out_chan) >= n) begin
              commit_active = 1'b0;
              latch_pending = 1'b1;
              out_chan      = '0;
            end
          end else begin
            out_bit = out_bit + 1'b1;
          end
        end
      end
      default: ;
    endcase
    o.blank_level = blank_on;
    o.busy_res    = commit_active || latch_pending;
    return o;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // request driver: holds a request until taken, idles at random
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_ch.valid   <= 1'b1;
        req_ch.action  <= pending_cmds[0].action;
        req_ch.channel <= pending_cmds[0].channel;
        req_ch.level   <= pending_cmds[0].level;
        void'(pending_cmds.pop_front());
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    led_cmd_t c;
    led_out_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        c.action  = req_ch.action;
        c.channel = req_ch.channel;
        c.level   = req_ch.level;
        expected_out.push_back(apply_request(c));
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_out.size() == 0) begin
          $display("%0t: result with no request outstanding, actual status %0d level %0d",
                   $time, res_ch.status, res_ch.read_level);
          mismatches++;
        end else begin
          want = expected_out.pop_front();
          check_field("read_level", want.read_level, res_ch.read_level);
          check_field("status", want.status, res_ch.status);
          check_field("serial_bit", want.serial_bit, res_ch.serial_bit);
          check_field("shift_pulse", want.shift_pulse, res_ch.shift_pulse);
          check_field("latch_pulse", want.latch_pulse, res_ch.latch_pulse);
          check_field("blank_level", want.blank_level, res_ch.blank_level);
          check_field("busy_res", want.busy_res, res_ch.busy_res);
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_cmd(logic [ACTION_W-1:0] a, int ch, int lvl);
    led_cmd_t c;
    c.action  = a;
    c.channel = CHANNEL_W'(ch);
    c.level   = LEVEL_BITS'(lvl);
    pending_cmds.push_back(c);
    if (a == ACT_TICK && gen_ticks_left > 0) gen_ticks_left--;
  endtask

  // mostly in range, some right at the edges, the rest anywhere
  function automatic int pick_channel(int n_chan);
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(n_chan - 1);
    if (r < 85) begin
      case ($urandom_range(5))
        0: return 0;
        1: return n_chan - 1;
        2: return n_chan;
        3: return STORE_DEPTH - 1;
        4: return STORE_DEPTH;
        default: return (1 << CHANNEL_W) - 1;
      endcase
    end
    return $urandom_range((1 << CHANNEL_W) - 1);
  endfunction

  function automatic int pick_level();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 20) return LEVEL_MAX;
    return $urandom_range(LEVEL_MAX);
  endfunction

  // any action, undefined codes and ticks too; a commit only while a commit run is being generated, else a read
  task automatic push_noise(int n_chan);
    int r;
    int ch;
    int lvl;
    r   = $urandom_range(99);
    ch  = pick_channel(n_chan);
    lvl = pick_level();
    if (r < 30) push_cmd(ACT_SET, ch, lvl);
    else if (r < 60) push_cmd(ACT_READ, ch, lvl);
    else if (r < 68) push_cmd(ACT_ON, ch, lvl);
    else if (r < 76) push_cmd(ACT_BLANK, ch, lvl);
    else if (r < 84) push_cmd($urandom_range(1) ? ACT_UNDEF_HI : ACT_UNDEF_LO, ch, lvl);
    else if (r < 92) push_cmd(ACT_TICK, ch, lvl);
    else if (gen_ticks_left > 0) push_cmd(ACT_COMMIT, ch, lvl);
    else push_cmd(ACT_READ, ch, lvl);
  endtask

  // sampled on the falling edge so driver and monitor updates have settled
  task automatic wait_drained();
    @(negedge clk);
    while (pending_cmds.size() != 0 || req_ch.valid || expected_out.size() != 0)
      @(negedge clk);
  endtask

  // two-phase register write; the block drops it while a commit is busy
  task automatic write_device_count(int value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_DEVICE_COUNT, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (!(commit_active || latch_pending)) dev_count = DEVCNT_W'(value);
  endtask

  // one random phase: optional register write, noise, then a full commit run if with_commit is set
  task automatic run_phase(int cfg_val, bit with_commit, int n_misc, int s_pct, int r_pct);
    int n_chan;
    wait_drained();
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    if (cfg_val >= 0) write_device_count(cfg_val);
    n_chan = chans_in_use(dev_count);
    repeat (n_misc) push_noise(n_chan);
    if (with_commit && gen_ticks_left == 0) begin
      push_cmd(ACT_COMMIT, $urandom_range(127), $urandom_range(LEVEL_MAX));
      gen_ticks_left = n_chan * LEVEL_BITS + 1;
    end
    while (gen_ticks_left > 0) begin
      if ($urandom_range(99) < 90)
        push_cmd(ACT_TICK, $urandom_range(127), $urandom_range(LEVEL_MAX));
      else
        push_noise(n_chan);
    end
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_ch.valid   = 1'b0;
    req_ch.action  = '0;
    req_ch.channel = '0;
    req_ch.level   = '0;
    res_ch.ready   = 1'b0;
    send_idle_pct  = 35;
    recv_idle_pct  = 72;
    mismatches     = 0;
    cycles         = 0;
    gen_ticks_left = 0;
    for (int i = 0; i < STORE_DEPTH; i++) level_mem[i] = LEVEL_MAX;
    out_chan      = '0;
    out_bit       = '0;
    commit_active = 1'b0;
    latch_pending = 1'b0;
    blank_on      = 1'b0;
    dev_count     = 1;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, range errors, blanking, ignored actions
    write_device_count(1);
    push_cmd(ACT_SET, 0, 0);
    push_cmd(ACT_SET, 23, LEVEL_MAX);
    push_cmd(ACT_SET, 1, 'hA5A);
    push_cmd(ACT_SET, 2, 'h5A5);
    push_cmd(ACT_SET, 24, 123);
    push_cmd(ACT_SET, 127, LEVEL_MAX);
    push_cmd(ACT_READ, 0, LEVEL_MAX);
    push_cmd(ACT_READ, 23, 0);
    push_cmd(ACT_READ, 1, 0);
    push_cmd(ACT_READ, 24, 0);
    push_cmd(ACT_READ, 127, 0);
    push_cmd(ACT_TICK, 127, LEVEL_MAX);
    push_cmd(ACT_BLANK, 0, 0);
    push_cmd(ACT_UNDEF_LO, 127, LEVEL_MAX);
    push_cmd(ACT_UNDEF_HI, 0, 0);
    push_cmd(ACT_COMMIT, 0, 0);
    gen_ticks_left = CHANNELS_PER_DEVICE * LEVEL_BITS + 1;
    push_cmd(ACT_TICK, 0, 0);
    push_cmd(ACT_TICK, 0, 0);

    // register write while the commit runs must not change its length
    wait_drained();
    write_device_count(DEVICES);

    // set and commit refused while busy, read and blanking still work
    push_cmd(ACT_SET, 0, 7);
    push_cmd(ACT_COMMIT, 0, 0);
    push_cmd(ACT_READ, 2, 0);
    push_cmd(ACT_ON, 0, 0);
    push_cmd(ACT_TICK, 0, 0);

    // random phases: receiver-heavy idling, sender-heavy idling, then none
    run_phase(-1, 1'b0, 35, 35, 72);
    run_phase(7, 1'b0, 35, 35, 72);
    run_phase(4, 1'b0, 35, 35, 72);
    run_phase(2, 1'b1, 35, 72, 35);
    run_phase(5, 1'b0, 35, 72, 35);
    run_phase(6, 1'b0, 35, 72, 35);
    run_phase(0, 1'b1, 35, 0, 0);
    run_phase(3, 1'b0, 35, 0, 0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/plc_pkg.sv
hdl/plc_if.sv
hdl/plc_store.sv
hdl/plc_cfg.sv
hdl/pwm_led_chain_loader.sv
test/pwm_led_chain_loader_test.sv
